[hdl/base32_key_encoder_top_assert.svh]
// Assertion macros shared by the base32 key encoder modules.
// A module that uses them must have aclk and aresetn in scope.
`ifndef BASE32_KEY_ENCODER_TOP_ASSERT_SVH
`define BASE32_KEY_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B32K_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("b32k: assertion failed");

// The condition must hold at every clock edge outside reset.
`define B32K_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("b32k: assertion failed");

`endif

[hdl/b32k_pkg.sv]
// Shared types, constants and the symbol alphabet of the base32 key encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package b32k_pkg;

    localparam int BYTE_W      = 8;
    localparam int SYM_W       = 5;
    localparam int CHAR_W      = 7;
    localparam int MAX_SYM     = 3;
    localparam int NSYM_W      = 2;
    localparam int IDX_W       = 2;
    localparam int HELD_W      = 3;
    localparam int REM_W       = 4;
    localparam int TOTAL_W     = 4;
    localparam int BUF_W       = 12;
    localparam int GROUP_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [GROUP_W-1:0] GROUP_LEN = 3'd5;
    localparam logic [HELD_W-1:0]  MAX_HELD  = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_A      = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_J      = 7'h4A;
    localparam logic [CHAR_W-1:0] CHAR_P      = 7'h50;
    localparam logic [CHAR_W-1:0] CHAR_2      = 7'h32;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 7'h2D;

    // One accepted byte, already cut into its symbols.
    typedef struct packed {
        logic [MAX_SYM-1:0][SYM_W-1:0] syms;
        logic [NSYM_W-1:0]             nsym;
        logic                          last;
    } b32k_entry_t;

    // The alphabet skips the letters I and O.
    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] v);
        logic [CHAR_W-1:0] v7;
        v7 = {2'b00, v};
        if (v < 5'd8) begin
            return CHAR_A + v7;
        end else if (v < 5'd13) begin
            return CHAR_J + v7 - 7'd8;
        end else if (v < 5'd24) begin
            return CHAR_P + v7 - 7'd13;
        end else begin
            return CHAR_2 + v7 - 7'd24;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/base32_key_encoder_top.sv]
// Top level of the base32 key encoder: configuration register, front end,
// queue and back end. Depends on b32k_pkg, b32k_front, b32k_queue, b32k_back.
//
//   Channel   Ports                                   Direction  Beat
//   ------    --------------------------------------  ---------  ---------------------
//   input     s_valid s_ready s_data_byte s_last_byte  in         one identifier byte
//   result    m_valid m_ready m_key_char m_last_char   out        one key character
//   config    cfg_wr_en cfg_wr_data                    in         hyphen_enable write
//
// A byte is accepted in the cycle it arrives whenever the four-entry queue has room.
// The back end drives one character per cycle from its output register while m_ready
// is high, one symbol of a byte after another; that register sets the rate.
// Reset is synchronous; there is no clearing pass.
// Input and output stall independently; the queue absorbs up to four cut bytes.
`default_nettype none

module base32_key_encoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_last_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_key_char,
    output logic            m_last_char
);
    import b32k_pkg::*;

    logic        hyphen_enable_reg, hyphen_enable_next;
    logic        push_valid, push_ready;
    logic        pop_valid, pop_ready;
    b32k_entry_t push_entry;
    b32k_entry_t pop_entry;

    assign hyphen_enable_next = cfg_wr_en ? cfg_wr_data : hyphen_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyphen_enable_reg <= 1'b0;
        end else begin
            hyphen_enable_reg <= hyphen_enable_next;
        end
    end

    b32k_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    b32k_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    b32k_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .hyphen_enable (hyphen_enable_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_char    (m_key_char),
        .m_last_char   (m_last_char)
    );

endmodule

`default_nettype wire

[hdl/b32k_front.sv]
// Front end: accepts identifier bytes and cuts the bit stream into 5-bit symbols.
// Depends on b32k_pkg and the assertion macro header.
`default_nettype none
`include "base32_key_encoder_top_assert.svh"

module b32k_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_data_byte,
    input  wire logic                       s_last_byte,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output b32k_pkg::b32k_entry_t           push_entry
);
    import b32k_pkg::*;

    logic [HELD_W-1:0]  held_reg, held_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [BUF_W-1:0]   bits;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] left;
    logic               two_full;
    logic               accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // Held bits sit below the new byte; bits above the total are always zero.
    always_comb begin
        bits     = (BUF_W'(s_data_byte) << held_reg) | BUF_W'(rem_reg);
        total    = TOTAL_W'(held_reg) + TOTAL_W'(BYTE_W);
        two_full = total >= 4'd10;
        left     = two_full ? (total - 4'd10) : (total - 4'd5);

        push_entry.syms[0] = bits[4:0];
        push_entry.syms[1] = bits[9:5];
        push_entry.syms[2] = {3'b000, bits[11:10]};
        push_entry.nsym    = (two_full ? 2'd2 : 2'd1)
                           + ((s_last_byte && (left != 4'd0)) ? 2'd1 : 2'd0);
        push_entry.last    = s_last_byte;
    end

    always_comb begin
        held_next = held_reg;
        rem_next  = rem_reg;
        if (accept) begin
            if (s_last_byte) begin
                held_next = '0;
                rem_next  = '0;
            end else begin
                held_next = left[HELD_W-1:0];
                rem_next  = two_full ? {2'b00, bits[11:10]} : bits[8:5];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            rem_reg  <= '0;
        end else begin
            held_reg <= held_next;
            rem_reg  <= rem_next;
        end
    end

    `B32K_ASSERT_ALWAYS(a_front_held_range, held_reg <= MAX_HELD)

endmodule

`default_nettype wire

[hdl/b32k_queue.sv]
// Short queue of cut bytes between the front end and the character emitter.
// Depends on b32k_pkg and the assertion macro header.
`default_nettype none
`include "base32_key_encoder_top_assert.svh"

module b32k_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire b32k_pkg::b32k_entry_t push_entry,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output b32k_pkg::b32k_entry_t      pop_entry
);
    import b32k_pkg::*;

    b32k_entry_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B32K_ASSERT_ALWAYS(a_queue_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `B32K_ASSERT_IMPLY(a_queue_full_ptrs, count_reg == QCNT_W'(QUEUE_DEPTH),
        wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

[hdl/b32k_back.sv]
// Back end: symbols to ASCII beats, adds hyphens; one per cycle unless stalled.
// Depends on b32k_pkg and the assertion macro header.
`default_nettype none
`include "base32_key_encoder_top_assert.svh"

module b32k_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  hyphen_enable,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire b32k_pkg::b32k_entry_t pop_entry,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [6:0]                 m_key_char,
    output logic                       m_last_char
);
    import b32k_pkg::*;

    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic                hyph_reg, hyph_next;
    logic                out_free;
    logic                is_end;
    logic                final_sym;
    logic                group_full;
    logic [GROUP_W-1:0]  group_inc;

    assign m_valid     = m_valid_reg;
    assign m_key_char  = char_reg;
    assign m_last_char = last_reg;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        is_end     = (idx_reg + 2'd1) == pop_entry.nsym;
        final_sym  = pop_entry.last && is_end;
        group_inc  = group_reg + 3'd1;
        group_full = group_inc == GROUP_LEN;

        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        group_next   = group_reg;
        hyph_next    = hyph_reg;
        pop_ready    = 1'b0;

        if (out_free) begin
            priority if (hyph_reg) begin
                // A pending hyphen goes out before the next queued symbol.
                m_valid_next = 1'b1;
                char_next    = CHAR_HYPHEN;
                last_next    = 1'b0;
                hyph_next    = 1'b0;
            end else if (pop_valid) begin
                m_valid_next = 1'b1;
                char_next    = sym_to_char(pop_entry.syms[idx_reg]);
                last_next    = final_sym;
                if (is_end) begin
                    pop_ready = 1'b1;
                    idx_next  = '0;
                end else begin
                    idx_next  = idx_reg + 2'd1;
                end
                group_next = (final_sym || group_full) ? '0 : group_inc;
                hyph_next  = hyphen_enable && group_full && !final_sym;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            group_reg   <= '0;
            hyph_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            group_reg   <= group_next;
            hyph_reg    <= hyph_next;
        end
    end

    `B32K_ASSERT_ALWAYS(a_back_group_range, group_reg < GROUP_LEN)
    `B32K_ASSERT_IMPLY(a_back_no_hyphen_after_last, m_valid_reg && last_reg, !hyph_reg)
    `B32K_ASSERT_IMPLY(a_back_idx_idle, !pop_valid, idx_reg == '0)

endmodule

`default_nettype wire
